>>> src/lgs_pkg.sv
// Shared types, constants, clamp/mask/next-row functions for Life generation.
package lgs_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int COL_AW      = $clog2(MAX_COLUMNS);
  localparam int CNT_W       = ROW_AW + 1;
  localparam int DIM_W       = 7;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  localparam logic [DIM_W-1:0] COLS_FULL = DIM_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0] ROWS_FULL = DIM_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] ROW_END   = CNT_W'(MAX_ROWS);

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_TOGGLE  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_CFG,
    DP_CLEAR,
    DP_SWEEP,
    DP_ADV,
    DP_RD_ITEM,
    DP_TOGGLE,
    DP_LOAD
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_ADV,
    S_TGL_RD,
    S_TGL_WR,
    S_CLEAR,
    S_FETCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } lgs_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic adv_done;
  } lgs_status_t;

  // Clamp a written dimension into 1..limit.
  function automatic logic [DIM_W-1:0] lgs_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > limit) begin
      res = limit;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Columns in use as a bit mask.
  function automatic logic [MAX_COLUMNS-1:0] lgs_col_mask(input logic [DIM_W-1:0] w);
    logic [MAX_COLUMNS-1:0] res;
    if (w >= COLS_FULL) begin
      res = '1;
    end else begin
      res = (MAX_COLUMNS'(1) << w[COL_AW-1:0]) - MAX_COLUMNS'(1);
    end
    return res;
  endfunction

  // B3/S23 on one row given the rows above and below; out-of-row cells count dead.
  function automatic logic [MAX_COLUMNS-1:0] lgs_next_row(
      input logic [MAX_COLUMNS-1:0] prv,
      input logic [MAX_COLUMNS-1:0] cur,
      input logic [MAX_COLUMNS-1:0] nxt);
    logic [MAX_COLUMNS-1:0] res;
    logic [MAX_COLUMNS-1:0] pl, pr, cl, cr, nl, nr;
    logic [3:0] n;
    pl = prv << 1;
    pr = prv >> 1;
    cl = cur << 1;
    cr = cur >> 1;
    nl = nxt << 1;
    nr = nxt >> 1;
    res = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      n = {3'b0, pl[i]} + {3'b0, prv[i]} + {3'b0, pr[i]} + {3'b0, cl[i]}
        + {3'b0, cr[i]} + {3'b0, nl[i]} + {3'b0, nxt[i]} + {3'b0, nr[i]};
      res[i] = (n == BIRTH_COUNT) || (cur[i] && (n == SURVIVE_LOW));
    end
    return res;
  endfunction

endpackage

>>> src/lgs_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lgs_dp.sv
// Datapath: grid RAM, row valid bits, config registers, generation window, result register.
module lgs_dp
  import lgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lgs_cmd_t               cmd,
  output lgs_status_t            status,
  input  logic [COL_AW-1:0]      item_x,
  input  logic [ROW_AW-1:0]      item_y,
  input  logic                   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data,
  output logic [MAX_COLUMNS-1:0] row_out,
  output logic                   alive_out
);

  logic [DIM_W-1:0]       width_r, width_nxt;
  logic [DIM_W-1:0]       height_r, height_nxt;
  logic [COL_AW-1:0]      x_r, x_nxt;
  logic [ROW_AW-1:0]      y_r, y_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MAX_COLUMNS-1:0] prev_r, prev_nxt;
  logic [MAX_COLUMNS-1:0] cur_r, cur_nxt;
  logic [MAX_ROWS-1:0]    row_vld_r, row_vld_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [MAX_COLUMNS-1:0] row_out_r, row_out_nxt;
  logic                   alive_out_r, alive_out_nxt;

  logic                   ram_we, ram_re;
  logic [ROW_AW-1:0]      ram_waddr, ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_wdata, ram_rdata;

  logic [MAX_COLUMNS-1:0] rd_row, mask, below_row, gen_row;
  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic                   in_region;

  lgs_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rows never written since reset or clear read as dead
  assign rd_row    = rd_vld_r ? ram_rdata : '0;
  assign mask      = lgs_col_mask(width_r);
  assign in_region = ({1'b0, x_r} < width_r) && ({1'b0, y_r} < height_r);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);
  // row cnt-1 arrives this cycle; beyond the used rows it counts dead
  assign below_row = (cnt_r <= height_r) ? rd_row : '0;
  assign gen_row   = lgs_next_row(prev_r, cur_r, below_row) & mask;

  assign status.sweep_done = (cnt_r == ROW_END);
  assign status.adv_done   = (cnt_r == height_r + CNT_W'(1));

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    row_vld_nxt   = row_vld_r;
    row_out_nxt   = row_out_r;
    alive_out_nxt = alive_out_r;
    ram_we        = 1'b0;
    ram_waddr     = y_r;
    ram_wdata     = rd_row;
    ram_re        = 1'b0;
    ram_raddr     = y_r;

    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_LATCH: begin
        x_nxt    = item_x;
        y_nxt    = item_y;
        cnt_nxt  = '0;
        prev_nxt = '0;
        cur_nxt  = '0;
      end
      DP_CFG: begin
        cnt_nxt = '0;
        if (cfg_index == CFG_GRID_WIDTH) begin
          width_nxt = lgs_clamp(cfg_data, COLS_FULL);
        end else begin
          height_nxt = lgs_clamp(cfg_data, ROWS_FULL);
        end
      end
      DP_CLEAR: begin
        row_vld_nxt = '0;
      end
      DP_SWEEP: begin
        // read row cnt, write back row cnt-1 trimmed to the region
        ram_re    = (cnt_r < ROW_END);
        ram_raddr = cnt_r[ROW_AW-1:0];
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_m1[ROW_AW-1:0];
        ram_wdata = (cnt_m1 < height_r) ? (rd_row & mask) : '0;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      DP_ADV: begin
        // read row cnt, write new row cnt-2 from the three-row window
        ram_re    = 1'b1;
        ram_raddr = cnt_r[ROW_AW-1:0];
        ram_we    = (cnt_r >= CNT_W'(2));
        ram_waddr = cnt_m2[ROW_AW-1:0];
        ram_wdata = gen_row;
        if (cnt_r != '0) begin
          prev_nxt = cur_r;
          cur_nxt  = below_row;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      DP_RD_ITEM: begin
        ram_re = 1'b1;
      end
      DP_TOGGLE: begin
        ram_we    = in_region;
        ram_wdata = rd_row ^ (MAX_COLUMNS'(1) << x_r);
      end
      DP_LOAD: begin
        row_out_nxt   = rd_row;
        alive_out_nxt = in_region & rd_row[x_r];
      end
      default: begin
      end
    endcase

    if (ram_we) begin
      row_vld_nxt[ram_waddr] = 1'b1;
    end
  end

  assign rd_vld_nxt = ram_re ? row_vld_r[ram_raddr] : rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= COLS_FULL;
      height_r  <= ROWS_FULL;
      cnt_r     <= '0;
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      cnt_r     <= cnt_nxt;
      row_vld_r <= row_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    row_out_r   <= row_out_nxt;
    alive_out_r <= alive_out_nxt;
  end

  assign row_out   = row_out_r;
  assign alive_out = alive_out_r;

endmodule

>>> src/lgs_ctrl.sv
// Controller: sequences item operations, region sweeps and the output handshake.
module lgs_ctrl
  import lgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  op_t         in_op,
  output logic        in_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output lgs_cmd_t    cmd,
  input  lgs_status_t status
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;

  assign load_ok   = !out_valid_r || out_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          state_nxt = S_SWEEP;
        end else if (in_valid) begin
          unique case (in_op)
            OP_TOGGLE:  state_nxt = S_TGL_RD;
            OP_CLEAR:   state_nxt = S_CLEAR;
            OP_ADVANCE: state_nxt = S_ADV;
            OP_READ:    state_nxt = S_FETCH;
            default:    state_nxt = S_FETCH;
          endcase
        end
      end
      S_SWEEP:  if (status.sweep_done) state_nxt = S_IDLE;
      S_ADV:    if (status.adv_done) state_nxt = S_FETCH;
      S_TGL_RD: state_nxt = S_TGL_WR;
      S_TGL_WR: state_nxt = S_FETCH;
      S_CLEAR:  state_nxt = S_FETCH;
      S_FETCH:  state_nxt = S_LOAD;
      S_LOAD:   if (load_ok) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = DP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.op = DP_CFG;
        end else if (in_valid) begin
          cmd.op = DP_LATCH;
        end
      end
      S_SWEEP:  cmd.op = DP_SWEEP;
      S_ADV:    cmd.op = DP_ADV;
      S_TGL_RD: cmd.op = DP_RD_ITEM;
      S_TGL_WR: cmd.op = DP_TOGGLE;
      S_CLEAR:  cmd.op = DP_CLEAR;
      S_FETCH:  cmd.op = DP_RD_ITEM;
      S_LOAD: begin
        if (load_ok) begin
          cmd.op        = DP_LOAD;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/life_generation_step_top.sv
// Top level of the Conway Life (B3/S23) generation block.
//
// Holds a 64 x 64 grid of one-bit cells in a RAM, one row per word, and applies
// one operation per input transaction: toggle a cell, clear the grid, advance
// one generation, or read. Every transaction returns one result: the bits of
// row cell_y after the operation and the state of cell (cell_x, cell_y). Only
// the top-left grid_width x grid_height region is live; edges count as dead,
// with no wrap. A read fetches the row and loads it into the result register;
// a clear resets the row valid bits and a toggle does a read-modify-write of
// one row before that read, and an advance first streams the generation one
// row per cycle through the single RAM read port with a three-row window; the
// next transaction can be taken once the result is loaded. A configuration
// write starts a sweep over every row that trims the grid to the new region;
// no transaction is taken during it. Row valid bits make a clear a single
// register update, also at reset. The result sits in an output register, so a
// new item is accepted while an earlier result still waits for out_tready.
module life_generation_step_top
  import lgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0 up: op[1:0], cell_x[7:2], cell_y[13:8], zero pad [15:14]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata, from bit 0 up: row_bits[63:0], cell_alive[64], zero pad [71:65]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // configuration: index 0 grid_width, index 1 grid_height
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  lgs_cmd_t               cmd;
  lgs_status_t            status;
  logic [MAX_COLUMNS-1:0] row_out;
  logic                   alive_out;

  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (op_t'(in_tdata[1:0])),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .status    (status)
  );

  lgs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .item_x    (in_tdata[7:2]),
    .item_y    (in_tdata[13:8]),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_out   (row_out),
    .alive_out (alive_out)
  );

  assign out_tdata = {7'b0, alive_out, row_out};

endmodule

>>> src/lgs_checker.sv
// Port-level checker for the Life generation block, bound to the top level.
module lgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accepted transaction
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !cfg_ready)
    else $error("input taken again while an item is in work");

  // a config write is followed by the region sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !cfg_ready && !in_tready)
    else $error("no sweep after config write");

  // pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:65] == 7'b0)
    else $error("nonzero pad in result");

endmodule

bind life_generation_step_top lgs_checker u_lgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
